// ===== sv/qcd_pkg.sv =====
// Shared types, constants and helper functions of the QOI chunk decoder.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package qcd_pkg;

    localparam int PIXEL_COUNT_BITS = 25;
    localparam int INDEX_DEPTH      = 64;
    localparam int INDEX_BITS       = $clog2(INDEX_DEPTH);
    localparam int COPY_BITS        = 7;

    localparam logic [7:0] BYTE_OP_RGB  = 8'hFE;
    localparam logic [7:0] BYTE_OP_RGBA = 8'hFF;

    localparam logic [1:0] TAG_INDEX = 2'b00;
    localparam logic [1:0] TAG_DIFF  = 2'b01;
    localparam logic [1:0] TAG_LUMA  = 2'b10;
    localparam logic [1:0] TAG_RUN   = 2'b11;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_RGB  = 2'd1,
        OP_RGBA = 2'd2,
        OP_LUMA = 2'd3
    } t_op;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_image;
    } t_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_of_run;
        logic       image_done;
    } t_out;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_pixel;

    localparam t_pixel PIXEL_INIT = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};

    typedef struct packed {
        logic accept;
        logic exec;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic produce;
        logic last_copy;
        logic out_free;
    } t_stat;

    // (3r + 5g + 7b + 11a) mod 64; only the low six bits of each channel matter
    function automatic logic [INDEX_BITS-1:0] color_hash(input t_pixel p);
        logic [11:0] sum;
        sum = 12'(p.r) * 12'd3 + 12'(p.g) * 12'd5 + 12'(p.b) * 12'd7 + 12'(p.a) * 12'd11;
        return sum[INDEX_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/qcd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module qcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/qcd_ctrl.sv =====
// Controller state machine of the QOI chunk decoder: accept, decode, emit.
// Depends on qcd_pkg for the command and status structs.
`default_nettype none

module qcd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire qcd_pkg::t_stat i_stat,
    output qcd_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.produce ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                // one copy per cycle while the output register can take it
                o_cmd.emit = i_stat.out_free;
                if (i_stat.out_free && i_stat.last_copy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== sv/qcd_datapath.sv =====
// Datapath of the QOI chunk decoder: pixel state, op decode, color index, output register.
// Depends on qcd_pkg and instantiates qcd_ram for the color index.
`default_nettype none

module qcd_datapath (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire qcd_pkg::t_cmd                         i_cmd,
    output qcd_pkg::t_stat                             o_stat,
    input  wire qcd_pkg::t_in                          i_in_data,
    input  wire logic                                  i_cfg_we,
    input  wire logic [qcd_pkg::PIXEL_COUNT_BITS-1:0]  i_cfg_data,
    input  wire logic                                  i_out_stall,
    output logic                                       o_out_valid,
    output qcd_pkg::t_out                              o_out_data
);

    logic [qcd_pkg::PIXEL_COUNT_BITS-1:0] r_pixel_count;
    logic [qcd_pkg::PIXEL_COUNT_BITS-1:0] r_emitted;
    logic [qcd_pkg::PIXEL_COUNT_BITS-1:0] remain;
    qcd_pkg::t_pixel                      r_prev;
    qcd_pkg::t_pixel                      px;
    qcd_pkg::t_pixel                      idx_px;
    qcd_pkg::t_pixel                      ram_rdata;
    logic [qcd_pkg::INDEX_DEPTH-1:0]      r_valid;
    qcd_pkg::t_op                         r_pending, n_pending;
    logic [1:0]                           r_left, n_left;
    logic [31:0]                          r_operand, n_operand;
    logic [7:0]                           r_byte;
    logic [qcd_pkg::COPY_BITS-1:0]        r_copies;
    logic [qcd_pkg::COPY_BITS-1:0]        copies_raw, copies_cap;
    logic [7:0]                           vg;
    logic                                 produce;
    logic                                 active;
    logic                                 out_free;
    logic [qcd_pkg::INDEX_BITS-1:0]       hash;

    qcd_ram #(
        .WIDTH ($bits(qcd_pkg::t_pixel)),
        .DEPTH (qcd_pkg::INDEX_DEPTH)
    ) u_index (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && produce),
        .i_waddr (hash),
        .i_wdata (px),
        .i_re    (i_cmd.accept),
        .i_raddr (i_in_data.data_byte[qcd_pkg::INDEX_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    // entries not written since image start read as zero
    assign idx_px = r_valid[r_byte[qcd_pkg::INDEX_BITS-1:0]] ? ram_rdata : '0;
    assign active = r_emitted < r_pixel_count;
    assign remain = r_pixel_count - r_emitted;
    assign vg     = 8'(n_operand[13:8]) + 8'd224;
    assign hash   = qcd_pkg::color_hash(px);

    always_comb begin
        n_pending  = r_pending;
        n_left     = r_left;
        n_operand  = r_operand;
        px         = r_prev;
        copies_raw = qcd_pkg::COPY_BITS'(1);
        produce    = 1'b0;
        if (active) begin
            if (r_pending != qcd_pkg::OP_NONE) begin
                n_operand = {r_operand[23:0], r_byte};
                if (r_left != 2'd0) begin
                    n_left = r_left - 2'd1;
                end else begin
                    produce   = 1'b1;
                    n_pending = qcd_pkg::OP_NONE;
                    unique case (r_pending)
                        qcd_pkg::OP_RGB: begin
                            px.r = n_operand[23:16];
                            px.g = n_operand[15:8];
                            px.b = n_operand[7:0];
                        end
                        qcd_pkg::OP_RGBA: begin
                            px.r = n_operand[31:24];
                            px.g = n_operand[23:16];
                            px.b = n_operand[15:8];
                            px.a = n_operand[7:0];
                        end
                        qcd_pkg::OP_LUMA: begin
                            px.r = r_prev.r + vg - 8'd8 + {4'd0, n_operand[7:4]};
                            px.g = r_prev.g + vg;
                            px.b = r_prev.b + vg - 8'd8 + {4'd0, n_operand[3:0]};
                        end
                        qcd_pkg::OP_NONE: begin
                        end
                    endcase
                end
            end else if (r_byte == qcd_pkg::BYTE_OP_RGB) begin
                n_pending = qcd_pkg::OP_RGB;
                n_left    = 2'd2;
                n_operand = '0;
            end else if (r_byte == qcd_pkg::BYTE_OP_RGBA) begin
                n_pending = qcd_pkg::OP_RGBA;
                n_left    = 2'd3;
                n_operand = '0;
            end else begin
                unique case (r_byte[7:6])
                    qcd_pkg::TAG_INDEX: begin
                        produce = 1'b1;
                        px      = idx_px;
                    end
                    qcd_pkg::TAG_DIFF: begin
                        produce = 1'b1;
                        px.r    = r_prev.r + {6'd0, r_byte[5:4]} - 8'd2;
                        px.g    = r_prev.g + {6'd0, r_byte[3:2]} - 8'd2;
                        px.b    = r_prev.b + {6'd0, r_byte[1:0]} - 8'd2;
                    end
                    qcd_pkg::TAG_LUMA: begin
                        n_pending = qcd_pkg::OP_LUMA;
                        n_left    = 2'd0;
                        n_operand = {26'd0, r_byte[5:0]};
                    end
                    qcd_pkg::TAG_RUN: begin
                        produce    = 1'b1;
                        copies_raw = {1'b0, r_byte[5:0]} + qcd_pkg::COPY_BITS'(1);
                    end
                endcase
            end
        end
    end

    // clip a run to the pixels left in the image
    assign copies_cap = (remain < qcd_pkg::PIXEL_COUNT_BITS'(copies_raw))
                        ? remain[qcd_pkg::COPY_BITS-1:0] : copies_raw;

    assign out_free = !o_out_valid || !i_out_stall;

    assign o_stat.produce   = produce;
    assign o_stat.last_copy = (r_copies == qcd_pkg::COPY_BITS'(1));
    assign o_stat.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= '0;
            r_emitted     <= '0;
            r_prev        <= qcd_pkg::PIXEL_INIT;
            r_valid       <= '0;
            r_pending     <= qcd_pkg::OP_NONE;
            r_left        <= 2'd0;
            r_copies      <= '0;
            o_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pixel_count <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_byte <= i_in_data.data_byte;
                if (i_in_data.start_image) begin
                    r_prev    <= qcd_pkg::PIXEL_INIT;
                    r_valid   <= '0;
                    r_pending <= qcd_pkg::OP_NONE;
                    r_left    <= 2'd0;
                    r_emitted <= '0;
                end
            end
            if (i_cmd.exec) begin
                r_pending <= n_pending;
                r_left    <= n_left;
                r_operand <= n_operand;
                if (produce) begin
                    r_prev        <= px;
                    r_valid[hash] <= 1'b1;
                    r_copies      <= copies_cap;
                end
            end
            if (i_cmd.emit) begin
                r_emitted              <= r_emitted + qcd_pkg::PIXEL_COUNT_BITS'(1);
                r_copies               <= r_copies - qcd_pkg::COPY_BITS'(1);
                o_out_data.red         <= r_prev.r;
                o_out_data.green       <= r_prev.g;
                o_out_data.blue        <= r_prev.b;
                o_out_data.alpha       <= r_prev.a;
                o_out_data.last_of_run <= (r_copies == qcd_pkg::COPY_BITS'(1));
                o_out_data.image_done  <=
                    ((r_emitted + qcd_pkg::PIXEL_COUNT_BITS'(1)) == r_pixel_count);
            end
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/qoi_chunk_decoder_top.sv =====
// Top level of the QOI chunk decoder: joins controller and datapath.
// Depends on qcd_pkg, qcd_ctrl, qcd_datapath and qcd_ram.
`default_nettype none

// Decodes the QOI chunk stream one byte per transfer and emits one transfer per
// decoded pixel. A byte that yields no pixel (op byte of a multi-byte op, any operand
// byte but the last, or any byte after the image is complete) is accepted and then
// decoded. A byte that yields n pixels is accepted, decoded and then emitted as n
// transfers, n being 1 for a single pixel op and up to 62 for a run; the decode cycle
// holds the color-index lookup, the pixel update and the index write-back, and the
// output register passes one pixel per cycle while the output side does not stall.
// Set pixel_count through the configuration port before the first byte; assert
// start_image on the first byte of each image. The 64-entry color index is cleared by
// per-entry valid flags, so there is no clearing pass after reset or at image start.
module qoi_chunk_decoder_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire qcd_pkg::t_in                         i_in_data,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output qcd_pkg::t_out                             o_out_data,
    input  wire logic                                 i_cfg_we,
    input  wire logic [qcd_pkg::PIXEL_COUNT_BITS-1:0] i_cfg_data
);

    qcd_pkg::t_cmd  cmd;
    qcd_pkg::t_stat stat;

    qcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    qcd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // an accepted byte is always decoded in the following cycle
    a_accept_then_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> cmd.exec)
        else $error("accepted byte not decoded in next cycle");

    // a new output pixel appears only after an emit command
    a_out_from_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> $past(cmd.emit))
        else $error("output valid rose without emit");

    // the last copy of a run frees the input side
    a_last_copy_frees : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && stat.last_copy) |=> !o_in_stall)
        else $error("input still stalled after last copy");

endmodule

`default_nettype wire
